/* sv/dprld_pkg.sv */
package dprld_pkg;

  // run symbols
  localparam logic [1:0] SYM_OPEN  = 2'd0;
  localparam logic [1:0] SYM_CLOSE = 2'd1;
  localparam logic [1:0] SYM_DOT   = 2'd2;
  localparam logic [1:0] SYM_PLUS  = 2'd3;

  // character codes
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // token queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]  symbol;
    logic [15:0] repeat_count;
    logic        run_present;
    logic        string_done;
    logic        bad_format;
  } result_t;

  // up to two tokens from one character, in order
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } front_push_t;

  function automatic result_t mk_run(input logic [1:0] sym, input logic [15:0] cnt);
    result_t r;
    r.symbol       = sym;
    r.repeat_count = cnt;
    r.run_present  = 1'b1;
    r.string_done  = 1'b0;
    r.bad_format   = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_empty();
    result_t r;
    r = '0;
    return r;
  endfunction

endpackage

/* sv/dprld_front.sv */
module dprld_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           char_code,
  input  logic                 end_of_string,
  output dprld_pkg::front_push_t push
);

  localparam int CW = COUNT_BITS;

  logic [1:0]    sym_r, sym_nxt;
  logic          pv_r, pv_nxt;
  logic          ds_r, ds_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          err_r, err_nxt;

  logic          is_open, is_plus, is_digit;
  logic [1:0]    new_sym;
  logic [3:0]    digit;
  logic [CW+3:0] mul;
  logic          ovf;
  logic [CW-1:0] sat;

  logic [1:0]    sym_post;
  logic          pv_post, ds_post, err_post;
  logic [CW-1:0] cnt_post;

  logic [CW-1:0]  pre_eff, post_eff;
  logic [CW+15:0] pre_ext, post_ext;

  logic             tok_f, tok_p, tok_e;
  dprld_pkg::result_t t_f, t_p, t_e;
  dprld_pkg::front_push_t p;

  always_comb begin
    is_open = 1'b0;
    new_sym = dprld_pkg::SYM_OPEN;
    unique case (char_code)
      dprld_pkg::CH_OPEN: begin
        is_open = 1'b1;
        new_sym = dprld_pkg::SYM_OPEN;
      end
      dprld_pkg::CH_CLOSE: begin
        is_open = 1'b1;
        new_sym = dprld_pkg::SYM_CLOSE;
      end
      dprld_pkg::CH_DOT: begin
        is_open = 1'b1;
        new_sym = dprld_pkg::SYM_DOT;
      end
      default: begin
        is_open = 1'b0;
        new_sym = dprld_pkg::SYM_OPEN;
      end
    endcase
  end

  assign is_plus  = (char_code == dprld_pkg::CH_PLUS);
  assign is_digit = (char_code >= dprld_pkg::CH_ZERO) && (char_code <= dprld_pkg::CH_NINE);
  assign digit    = 4'(char_code - dprld_pkg::CH_ZERO);

  // count * 10 + digit, saturating
  assign mul = ({4'b0, cnt_r} << 3) + ({4'b0, cnt_r} << 1) + {{CW{1'b0}}, digit};
  assign ovf = |mul[CW+3:CW];
  assign sat = ovf ? {CW{1'b1}} : mul[CW-1:0];

  always_comb begin
    sym_post = sym_r;
    pv_post  = pv_r;
    ds_post  = ds_r;
    cnt_post = cnt_r;
    err_post = err_r;
    if (is_open) begin
      sym_post = new_sym;
      pv_post  = 1'b1;
      ds_post  = 1'b0;
      cnt_post = '0;
    end else if (is_plus) begin
      sym_post = dprld_pkg::SYM_OPEN;
      pv_post  = 1'b0;
      ds_post  = 1'b0;
      cnt_post = '0;
    end else if (is_digit) begin
      if (pv_r) begin
        cnt_post = sat;
        ds_post  = 1'b1;
        err_post = err_r | ovf;
      end else begin
        err_post = 1'b1;
      end
    end else begin
      err_post = 1'b1;
    end
  end

  // effective run length, cut to the 16-bit port
  assign pre_eff  = ds_r ? cnt_r : CW'(1);
  assign post_eff = ds_post ? cnt_post : CW'(1);
  assign pre_ext  = {16'b0, pre_eff};
  assign post_ext = {16'b0, post_eff};

  assign tok_f = pv_r && (is_open || is_plus);
  assign tok_p = is_plus;
  assign tok_e = pv_post && end_of_string;
  assign t_f   = dprld_pkg::mk_run(sym_r, pre_ext[15:0]);
  assign t_p   = dprld_pkg::mk_run(dprld_pkg::SYM_PLUS, 16'd1);
  assign t_e   = dprld_pkg::mk_run(sym_post, post_ext[15:0]);

  always_comb begin
    p.r0 = dprld_pkg::mk_empty();
    p.r1 = dprld_pkg::mk_empty();
    p.n  = 2'd0;
    if (tok_f) begin
      p.r0 = t_f;
      if (tok_p) begin
        p.r1 = t_p;
        p.n  = 2'd2;
      end else if (tok_e) begin
        p.r1 = t_e;
        p.n  = 2'd2;
      end else begin
        p.n  = 2'd1;
      end
    end else if (tok_p) begin
      p.r0 = t_p;
      p.n  = 2'd1;
    end else if (tok_e) begin
      p.r0 = t_e;
      p.n  = 2'd1;
    end
    if (end_of_string) begin
      if (p.n == 2'd2) begin
        p.r1.string_done = 1'b1;
        p.r1.bad_format  = err_post;
      end else begin
        p.n              = 2'd1;
        p.r0.string_done = 1'b1;
        p.r0.bad_format  = err_post;
      end
    end
    if (!accept) begin
      p.n = 2'd0;
    end
  end

  assign push = p;

  always_comb begin
    sym_nxt = sym_r;
    pv_nxt  = pv_r;
    ds_nxt  = ds_r;
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    if (accept) begin
      if (end_of_string) begin
        sym_nxt = dprld_pkg::SYM_OPEN;
        pv_nxt  = 1'b0;
        ds_nxt  = 1'b0;
        cnt_nxt = '0;
        err_nxt = 1'b0;
      end else begin
        sym_nxt = sym_post;
        pv_nxt  = pv_post;
        ds_nxt  = ds_post;
        cnt_nxt = cnt_post;
        err_nxt = err_post;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r <= dprld_pkg::SYM_OPEN;
      pv_r  <= 1'b0;
      ds_r  <= 1'b0;
      cnt_r <= '0;
      err_r <= 1'b0;
    end else begin
      sym_r <= sym_nxt;
      pv_r  <= pv_nxt;
      ds_r  <= ds_nxt;
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

/* sv/dprld_queue.sv */
module dprld_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dprld_pkg::front_push_t push,
  input  logic                   pop,
  output dprld_pkg::result_t     head,
  output logic                   empty,
  output logic                   full
);

  dprld_pkg::result_t mem_r [dprld_pkg::QDEPTH];

  logic [dprld_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [dprld_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [dprld_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                         do_pop;
  logic [dprld_pkg::QPTR_W-1:0] wr_ptr_1;

  assign empty    = (cnt_r == '0);
  // room for two tokens must be there before a character is taken
  assign full     = (cnt_r > dprld_pkg::QCNT_W'(dprld_pkg::QDEPTH - 2));
  assign head     = mem_r[rd_ptr_r];
  assign do_pop   = pop && !empty;
  assign wr_ptr_1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + dprld_pkg::QPTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + dprld_pkg::QPTR_W'(do_pop);
    cnt_nxt    = cnt_r + dprld_pkg::QCNT_W'(push.n) - dprld_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* sv/dot_paren_run_length_decoder.sv */
// a character's tokens are registered in the queue and shown from its head
// throughput: one character per cycle while the token queue has room for two tokens;
//   results leave at one per cycle while out_pop is asserted, so strings that average
//   more than one token per character are paced by the single result port
// reset: rst_n synchronous active low, clears the open run, the error flag and the queue
module dot_paren_run_length_decoder #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_string,
  // result channel
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_symbol,
  output logic [15:0] out_repeat_count,
  output logic        out_run_present,
  output logic        out_string_done,
  output logic        out_bad_format
);

  logic                   in_accept;
  dprld_pkg::front_push_t push;
  dprld_pkg::result_t     head;

  // an input transaction completes when the queue can take two tokens
  assign in_accept = in_push && !in_full;

  // front: classifies the character, keeps the open run and its count,
  // and forms zero, one or two tokens
  dprld_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .char_code     (in_char_code),
    .end_of_string (in_end_of_string),
    .push          (push)
  );

  // back: token queue whose head drives the result ports
  dprld_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_pop),
    .head  (head),
    .empty (out_empty),
    .full  (in_full)
  );

  // result fields straight from the queue head
  assign out_symbol       = head.symbol;
  assign out_repeat_count = head.repeat_count;
  assign out_run_present  = head.run_present;
  assign out_string_done  = head.string_done;
  assign out_bad_format   = head.bad_format;

endmodule

/* sv/dprld_checker.sv */
module dprld_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic [1:0]  out_symbol,
  input logic [15:0] out_repeat_count,
  input logic        out_run_present,
  input logic        out_string_done,
  input logic        out_bad_format
);

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result waiting after reset");

  // a token without a run carries zero symbol and count
  a_norun_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_run_present) |-> (out_symbol == 2'd0 && out_repeat_count == 16'd0))
    else $error("token without run has nonzero fields");

  // a token without a run only ever closes a string
  a_norun_final: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_run_present) |-> out_string_done)
    else $error("token without run is not final");

  // the error flag shows only on a string's final token
  a_bad_final: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_bad_format) |-> out_string_done)
    else $error("error flag on non-final token");

endmodule

bind dot_paren_run_length_decoder dprld_checker u_dprld_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_empty        (out_empty),
  .out_symbol       (out_symbol),
  .out_repeat_count (out_repeat_count),
  .out_run_present  (out_run_present),
  .out_string_done  (out_string_done),
  .out_bad_format   (out_bad_format)
);
